// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

	// Field widths
	localparam int IDX_W   = 8;   // block index
	localparam int CNT_W   = 9;   // block count, fresh pointer, used count
	localparam int SIZE_W  = 16;  // block and request size in bytes
	localparam int BYTES_W = 24;  // used bytes
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;

	// Hard ceiling on pool size set by the index width
	localparam int POOL_CEIL = 256;

	// Reset values of the configuration registers
	localparam int RST_BLOCK_COUNT = 256;
	localparam int RST_BLOCK_SIZE  = 16;
	localparam int DEF_MAX_BLOCKS  = 256;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_SIZE  = 1'd1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RESET   = 2'd2
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SIZE  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [BYTES_W-1:0] used_bytes;
		logic [CNT_W-1:0]   used_count;
		status_t            status;
		logic [IDX_W-1:0]   granted_index;
	} result_t;

endpackage

// ===== design/fbpa_link_mem.sv =====
// Free-list link memory: one write port, one read port, registered read
// data with write-through when both ports hit the same entry.
module fbpa_link_mem #(
	parameter int DEPTH = fbpa_pkg::DEF_MAX_BLOCKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [fbpa_pkg::IDX_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [fbpa_pkg::IDX_W-1:0] rdata
);

	logic [fbpa_pkg::IDX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/fbpa_core.sv =====
// Pool state and single-pass request decode.
// head_q is the top of the free list, second_q its link, and the link memory
// read register holds the link of second_q, so a pop never waits on a read.
module fbpa_core #(
	parameter int DEPTH = fbpa_pkg::DEF_MAX_BLOCKS,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  fbpa_pkg::opcode_t            opcode,
	input  logic [fbpa_pkg::SIZE_W-1:0]  request_size,
	input  logic [fbpa_pkg::IDX_W-1:0]   block_index,
	input  logic [fbpa_pkg::CNT_W-1:0]   block_count,
	input  logic [fbpa_pkg::SIZE_W-1:0]  block_size,
	output fbpa_pkg::result_t            result
);

	localparam logic [fbpa_pkg::CNT_W-1:0] LIMIT = fbpa_pkg::CNT_W'(DEPTH);

	logic [fbpa_pkg::IDX_W-1:0] head_q, head_d;
	logic [fbpa_pkg::IDX_W-1:0] second_q, second_d;
	logic [fbpa_pkg::IDX_W-1:0] third;
	logic                       nonempty_q, nonempty_d;
	logic [fbpa_pkg::CNT_W-1:0] fresh_q, fresh_d;
	logic [fbpa_pkg::CNT_W-1:0] count_q, count_d;
	logic [fbpa_pkg::CNT_W-1:0] eff_count;
	logic                       mem_we;
	logic [fbpa_pkg::IDX_W-1:0] granted;
	fbpa_pkg::status_t          status;
	logic [fbpa_pkg::CNT_W+fbpa_pkg::SIZE_W-1:0] product;

	fbpa_link_mem #(.DEPTH(DEPTH)) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(block_index)),
		.wdata (head_q),
		.raddr (AW'(second_d)),
		.rdata (third)
	);

	assign eff_count = (block_count < LIMIT) ? block_count : LIMIT;

	always_comb begin
		head_d     = head_q;
		second_d   = second_q;
		nonempty_d = nonempty_q;
		fresh_d    = fresh_q;
		count_d    = count_q;
		mem_we     = 1'b0;
		granted    = '0;
		status     = fbpa_pkg::ST_OK;
		if (accept) begin
			case (opcode)
				fbpa_pkg::OP_ALLOC: begin
					if (request_size != block_size) begin
						status = fbpa_pkg::ST_SIZE;
					end else if (nonempty_q) begin
						granted    = head_q;
						head_d     = second_q;
						second_d   = third;
						count_d    = count_q + 1'b1;
						nonempty_d = (fresh_q > count_d);
					end else if (fresh_q < eff_count) begin
						granted = fresh_q[fbpa_pkg::IDX_W-1:0];
						fresh_d = fresh_q + 1'b1;
						count_d = count_q + 1'b1;
					end else begin
						status = fbpa_pkg::ST_EMPTY;
					end
				end
				fbpa_pkg::OP_RELEASE: begin
					if ((fbpa_pkg::CNT_W'(block_index) >= eff_count) || (count_q == '0)) begin
						status = fbpa_pkg::ST_RANGE;
					end else begin
						mem_we     = 1'b1;
						head_d     = block_index;
						second_d   = head_q;
						nonempty_d = 1'b1;
						count_d    = count_q - 1'b1;
					end
				end
				fbpa_pkg::OP_RESET: begin
					head_d     = '0;
					nonempty_d = 1'b0;
					fresh_d    = '0;
					count_d    = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			second_q   <= '0;
			nonempty_q <= 1'b0;
			fresh_q    <= '0;
			count_q    <= '0;
		end else begin
			head_q     <= head_d;
			second_q   <= second_d;
			nonempty_q <= nonempty_d;
			fresh_q    <= fresh_d;
			count_q    <= count_d;
		end
	end

	assign product = (fbpa_pkg::CNT_W + fbpa_pkg::SIZE_W)'(count_d)
		* (fbpa_pkg::CNT_W + fbpa_pkg::SIZE_W)'(block_size);

	assign result.granted_index = granted;
	assign result.status        = status;
	assign result.used_count    = count_d;
	assign result.used_bytes    = product[fbpa_pkg::BYTES_W-1:0];

	// Listed blocks always come from blocks already handed out fresh
	a_list_within_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> (fresh_q > count_q))
		else $error("free list nonempty with no released block outstanding");

	a_count_within_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fresh_q)
		else $error("used count above blocks ever handed out");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= LIMIT)
		else $error("fresh pointer beyond pool");

	a_release_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == fbpa_pkg::OP_RELEASE) && (status == fbpa_pkg::ST_OK))
		|=> (head_q == $past(block_index)) && nonempty_q)
		else $error("released block not on top of free list");

endmodule

// ===== design/fixed_block_pool_allocator.sv =====
// Fixed-size block pool allocator.
// Requests enter on the s_axis stream: tuser carries the opcode (allocate,
// release, reset pool), tdata the request size and the block index. Every
// request yields exactly one result transaction on m_axis with the granted
// block, a status code and the usage after the request.
// Allocate reuses released blocks last-in-first-out, otherwise hands out the
// lowest never-used block. Blocks are indices, not addresses.
// The result is registered and valid in the cycle after the request transaction.
// Throughput: one transaction per cycle while m_axis accepts results. The
// free-list link memory is read one link ahead of the list head, so
// consecutive pops and pushes need only the write-through path of that memory.
// A stalled m_axis holds its result; s_axis_tready stays high while the
// output register is empty or being drained in the same cycle.
// Reset clears the pool (nothing allocated, empty free list) and loads
// block_count = 256, block_size = 16. The link memory is not cleared: its
// entries are always written before the free list reaches them.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 block count,
// 1 block size). The user writes only while no request is in flight (unenforced).
module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = fbpa_pkg::DEF_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // request_size[15:0], block_index[23:16]
	input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // granted_index[7:0], status[9:8],
	                                    // used_count[18:10], used_bytes[42:19], zero
	input  logic                                 cfg_we,
	input  logic [fbpa_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [fbpa_pkg::SIZE_W-1:0]          cfg_wdata
);

	// link memory depth: pool can never exceed what an 8-bit index names
	localparam int DEPTH = (MAX_BLOCKS < fbpa_pkg::POOL_CEIL) ? MAX_BLOCKS
		: fbpa_pkg::POOL_CEIL;

	logic [fbpa_pkg::CNT_W-1:0]  block_count_q;
	logic [fbpa_pkg::SIZE_W-1:0] block_size_q;
	logic                        accept;
	fbpa_pkg::result_t           result;
	fbpa_pkg::result_t           result_q;
	logic                        out_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= fbpa_pkg::CNT_W'(fbpa_pkg::RST_BLOCK_COUNT);
			block_size_q  <= fbpa_pkg::SIZE_W'(fbpa_pkg::RST_BLOCK_SIZE);
		end else if (cfg_we) begin
			case (cfg_addr)
				fbpa_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[fbpa_pkg::CNT_W-1:0];
				fbpa_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// take a new request whenever the result slot is free or draining
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	fbpa_core #(.DEPTH(DEPTH)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (fbpa_pkg::opcode_t'(s_axis_tuser)),
		.request_size (s_axis_tdata[15:0]),
		.block_index  (s_axis_tdata[23:16]),
		.block_count  (block_count_q),
		.block_size   (block_size_q),
		.result       (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, result_q.used_bytes, result_q.used_count,
		result_q.status, result_q.granted_index};

endmodule
